// ===== hw/rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the row reduction unit
// Widths, register map, reduction modes, sequencer states and the request
// format of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int ELEM_W  = 32;
	localparam int SUM_W   = 48;
	localparam int POS_W   = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int DEF_MAX_ROW_LENGTH = 65536;
	localparam int DEF_VALUE_WIDTH    = 32;

	// one quotient bit per divide step
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// word index of the mode register
	localparam logic [PADDR_W-3:0] REG_MODE = '0;

	typedef enum logic [1:0] {
		MODE_SUM    = 2'd0,
		MODE_MEAN   = 2'd1,
		MODE_MAX    = 2'd2,
		MODE_ARGMAX = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_CMP,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_FIN
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t                 op;
		logic signed [SUM_W-1:0] a;
		logic signed [SUM_W-1:0] b;
	} alu_req_t;

endpackage

// ===== hw/rtl/rrs_if.sv =====
// ----------------------------------------------------------------------------
// rrs_elem_if / rrs_result_if: item channels of the row reduction unit
// Valid/ready channels carrying row elements in and reduced results out.
// ----------------------------------------------------------------------------
interface rrs_elem_if;
	import rrs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element_value;
	logic                     row_last;

	modport source (output valid, output element_value, output row_last, input ready);
	modport sink   (input valid, input element_value, input row_last, output ready);
endinterface

interface rrs_result_if;
	import rrs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] reduced_value;
	logic [POS_W-1:0]        best_position;
	logic                    row_too_long;

	modport source (output valid, output reduced_value, output best_position,
		output row_too_long, input ready);
	modport sink   (input valid, input reduced_value, input best_position,
		input row_too_long, output ready);
endinterface

// ===== hw/rtl/rrs_alu.sv =====
// ----------------------------------------------------------------------------
// rrs_alu: shared add/subtract unit
// One signed adder with a guard bit; serves accumulate, compare, negate and
// the divide steps.
// ----------------------------------------------------------------------------
module rrs_alu (
	input  rrs_pkg::alu_req_t                req,
	output logic signed [rrs_pkg::SUM_W:0]   res
);
	import rrs_pkg::*;

	logic signed [SUM_W:0] a_x;
	logic signed [SUM_W:0] b_x;

	assign a_x = {req.a[SUM_W-1], req.a};
	assign b_x = {req.b[SUM_W-1], req.b};

	always_comb begin
		unique case (req.op)
			ALU_ADD: res = a_x + b_x;
			ALU_SUB: res = a_x - b_x;
			default: res = a_x + b_x;
		endcase
	end
endmodule

// ===== hw/rtl/rrs_cfg.sv =====
// ----------------------------------------------------------------------------
// rrs_cfg: configuration register port
// APB-style access to the reduction mode register.
// ----------------------------------------------------------------------------
module rrs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
	input  logic [rrs_pkg::PDATA_W-1:0]   pwdata,
	output logic [rrs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output rrs_pkg::mode_t                reduce_mode
);
	import rrs_pkg::*;

	logic  hit;
	mode_t mode_q;

	assign pready      = 1'b1;
	assign hit         = (paddr[PADDR_W-1:2] == REG_MODE);
	assign reduce_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
		end else if (psel && penable && pwrite && pready && hit) begin
			mode_q <= mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = PDATA_W'(mode_q);
		end
	end
endmodule

// ===== hw/rtl/row_reduce_sum_mean_max_argmax_unit.sv =====
// ----------------------------------------------------------------------------
// row_reduce_sum_mean_max_argmax_unit: streaming row sum/mean/max/argmax
// Takes one row element per item and gives one result per row in the mode
// set in the mode register, all arithmetic through one shared adder.
// ----------------------------------------------------------------------------
//
//  channel  | kind            | payload
//  ---------+-----------------+---------------------------------------------
//  elem     | valid/ready in  | element_value[31:0] signed, row_last
//  result   | valid/ready out | reduced_value[47:0] signed, best_position,
//           |                 | row_too_long
//  apb      | register port   | reduce_mode at byte address 0
//
// Steps: an element passes through accept, accumulate and compare, and the
// last one of a row goes on to load the result register. In mean mode the
// row end adds a negate, 48 restoring divide steps and a sign fix, all on
// the shared adder. Elements past MAX_ROW_LENGTH are accepted and dropped.
// Reset clears the running row state, the mode and the result valid at once.
// A waiting result does not block new elements; only a row end stalls until
// the result register is free.
module row_reduce_sum_mean_max_argmax_unit #(
	parameter int MAX_ROW_LENGTH = rrs_pkg::DEF_MAX_ROW_LENGTH,
	parameter int VALUE_WIDTH    = rrs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rrs_elem_if.sink                      elem,
	rrs_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
	input  logic [rrs_pkg::PDATA_W-1:0]   pwdata,
	output logic [rrs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import rrs_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROW_LENGTH + 1);
	localparam int IDX_W = $clog2(MAX_ROW_LENGTH);

	state_t state_q, state_d;
	mode_t  reduce_mode;

	// running row state
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [VALUE_WIDTH-1:0] best_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CNT_W-1:0]              count_q;
	logic                          started_q;
	logic                          ovf_q;

	// current element
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          last_q;

	// divider: remainder and dividend/quotient shift register
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dq_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    shifted;

	// result register
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] out_value_q;
	logic [POS_W-1:0]        out_pos_q;
	logic                    out_ovf_q;

	alu_req_t              alu_req;
	logic signed [SUM_W:0] alu_res;
	logic                  accept;
	logic                  load_out;
	logic                  row_full;
	logic                  greater;
	logic                  elem_ready;
	state_t                end_state;

	rrs_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.reduce_mode(reduce_mode)
	);

	rrs_alu u_alu (
		.req(alu_req),
		.res(alu_res)
	);

	assign elem.ready   = elem_ready;
	assign accept       = elem.valid && elem_ready;
	assign row_full     = (count_q == CNT_W'(MAX_ROW_LENGTH));
	assign shifted      = {rem_q, dq_q[SUM_W-1]};
	// strictly greater only, so the first maximum keeps its place
	assign greater      = !alu_res[SUM_W] && (alu_res != '0);
	assign end_state    = (reduce_mode == MODE_MEAN) ? ST_ABS : ST_FIN;

	assign result.valid         = out_valid_q;
	assign result.reduced_value = out_value_q;
	assign result.best_position = out_pos_q;
	assign result.row_too_long  = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and the shared adder's operands
	always_comb begin
		state_d    = state_q;
		elem_ready = 1'b0;
		load_out   = 1'b0;
		alu_req    = '{op: ALU_ADD, a: '0, b: '0};
		unique case (state_q)
			ST_IDLE: begin
				elem_ready = 1'b1;
				if (elem.valid) begin
					if (!row_full) begin
						state_d = ST_ACC;
					end else if (elem.row_last) begin
						state_d = end_state;
					end
				end
			end
			ST_ACC: begin
				alu_req = '{op: ALU_ADD, a: sum_q, b: SUM_W'(val_q)};
				state_d = ST_CMP;
			end
			ST_CMP: begin
				alu_req = '{op: ALU_SUB, a: SUM_W'(val_q), b: SUM_W'(best_q)};
				state_d = last_q ? end_state : ST_IDLE;
			end
			ST_ABS: begin
				alu_req = '{op: ALU_SUB, a: '0, b: sum_q};
				state_d = ST_DIV;
			end
			ST_DIV: begin
				alu_req = '{op: ALU_SUB, a: SUM_W'(shifted), b: SUM_W'(count_q)};
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				alu_req = '{op: ALU_SUB, a: '0, b: dq_q};
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold here while the previous result is still unclaimed
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// running row state, cleared at reset and when a row's result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			best_q      <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			started_q   <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				sum_q       <= '0;
				best_q      <= '0;
				idx_q       <= '0;
				count_q     <= '0;
				started_q   <= 1'b0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (result.ready) begin
					out_valid_q <= 1'b0;
				end
				// drop elements past the row limit, remember the overflow
				if (accept && row_full) begin
					ovf_q <= 1'b1;
				end
				if (state_q == ST_ACC) begin
					sum_q <= alu_res[SUM_W-1:0];
				end
				if (state_q == ST_CMP) begin
					if (!started_q || greater) begin
						best_q    <= val_q;
						idx_q     <= count_q[IDX_W-1:0];
						started_q <= 1'b1;
					end
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// element capture, divider and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= elem.element_value[VALUE_WIDTH-1:0];
			last_q <= elem.row_last;
		end
		unique case (state_q)
			ST_ABS: begin
				dq_q   <= sum_q[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_q;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				// restoring step: keep the difference when it does not go negative
				rem_q  <= alu_res[SUM_W] ? shifted[CNT_W-1:0] : alu_res[CNT_W-1:0];
				dq_q   <= {dq_q[SUM_W-2:0], !alu_res[SUM_W]};
				step_q <= step_q + STEP_W'(1);
			end
			ST_SIGN: begin
				// truncate toward zero: negate the magnitude quotient for a negative sum
				if (sum_q[SUM_W-1]) begin
					dq_q <= alu_res[SUM_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			case (reduce_mode)
				MODE_SUM:    out_value_q <= sum_q;
				MODE_MEAN:   out_value_q <= dq_q;
				MODE_MAX:    out_value_q <= SUM_W'(best_q);
				MODE_ARGMAX: out_value_q <= SUM_W'(idx_q);
				default:     out_value_q <= sum_q;
			endcase
			out_pos_q <= POS_W'(idx_q);
			out_ovf_q <= ovf_q;
		end
	end
endmodule

// ===== hw/rtl/rrs_chk.sv =====
// ----------------------------------------------------------------------------
// rrs_chk: port-level checks of the row reduction unit
// Watches the item channels and reset, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          elem_valid,
	input logic                          elem_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [rrs_pkg::SUM_W-1:0] reduced_value,
	input logic [rrs_pkg::POS_W-1:0]     best_position,
	input logic                          row_too_long
);
	import rrs_pkg::*;

	// a stalled result keeps its valid and its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(reduced_value)
			&& $stable(best_position) && $stable(row_too_long))
		else $error("result changed while stalled");

	// a new result appears only as the sequencer returns to taking elements
	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> elem_ready)
		else $error("result rose while elements blocked");

	// an accepted element is never followed at once by a rising result valid
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_ready |=> !$rose(result_valid))
		else $error("result one cycle after element");

	// no result is offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid in reset");
endmodule

bind row_reduce_sum_mean_max_argmax_unit rrs_chk u_rrs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.elem_valid   (elem.valid),
	.elem_ready   (elem.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.reduced_value(result.reduced_value),
	.best_position(result.best_position),
	.row_too_long (result.row_too_long)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the streaming row sum/mean/max/argmax unit
// Drives rows of signed Q16.16 elements into the unit, predicts each row result
// in the current mode, and compares every result field by field. It covers
// field extremes, ties, a mode change within a row, register access, long rows
// whose sums pass the element width, and random rows under idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
	import rrs_pkg::*;

	localparam int MAX_ROW_LEN   = DEF_MAX_ROW_LENGTH;
	localparam int LONG_ROW_LEN  = 80;
	// wait after draining so a mean row end can finish its divide and sign fix
	localparam int SETTLE_CYCLES = 64;
	localparam int SEGMENT_ITEMS = 80;

	localparam logic [PADDR_W-1:0] MODE_ADDR  = {REG_MODE, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = MODE_ADDR + 3'd4;

	localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SUM_W-1:0] value;
		logic [POS_W-1:0]        pos;
		logic                    too_long;
	} row_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	rrs_elem_if   elem_ch ();
	rrs_result_if result_ch ();

	row_reduce_sum_mean_max_argmax_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.elem    (elem_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Row state as the unit should hold it, plus the mode it should read
	longint                   row_sum;
	logic signed [ELEM_W-1:0] row_best;
	int                       row_best_pos;
	int                       row_count;
	bit                       row_open;
	bit                       row_clipped;
	mode_t                    mode_shadow;

	row_result_t              pending_rows[$];
	row_result_t              head_row;
	int                       mismatch_count;

	// Chance in percent that the sender idles before an item, and that the
	// result side holds ready low in a cycle
	int                       elem_gap_pct;
	int                       result_stall_pct;

	logic signed [ELEM_W-1:0] row_buf[$];

	always #5 clk = ~clk;

	// Fold one accepted element into the row; on the row end queue its result
	// in the current mode and clear the row.
	task automatic accumulate_element(input logic signed [ELEM_W-1:0] v, input logic last);
		row_result_t r;
		longint      q;
		if (row_count >= MAX_ROW_LEN) begin
			// past the length limit: drop the element, only flag the row
			row_clipped = 1'b1;
		end else begin
			row_sum += longint'(v);
			// strictly greater only, so the first of equal maxima stays
			if (!row_open || v > row_best) begin
				row_best     = v;
				row_best_pos = row_count;
				row_open     = 1'b1;
			end
			row_count++;
		end
		if (last) begin
			case (mode_shadow)
				MODE_SUM: q = row_sum;
				// SV signed divide truncates toward zero
				MODE_MEAN: q = (row_count > 0) ? row_sum / longint'(row_count) : 64'sd0;
				MODE_MAX: q = longint'(row_best);
				default: q = longint'(row_best_pos);
			endcase
			r.value    = q[SUM_W-1:0];
			r.pos      = row_best_pos[POS_W-1:0];
			r.too_long = row_clipped;
			pending_rows.push_back(r);
			row_sum      = 0;
			row_best     = '0;
			row_best_pos = 0;
			row_count    = 0;
			row_open     = 1'b0;
			row_clipped  = 1'b0;
		end
	endtask

	// Sample both channels at the rising edge: check results against the
	// oldest expectation first, then fold in an accepted element.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_rows.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result value=%0d pos=%0d too_long=%0b", $time,
						result_ch.reduced_value, result_ch.best_position, result_ch.row_too_long);
				end else begin
					head_row = pending_rows.pop_front();
					if (result_ch.reduced_value !== head_row.value) begin
						mismatch_count++;
						$display("%0t: reduced_value expected %0d got %0d", $time,
							head_row.value, result_ch.reduced_value);
					end
					if (result_ch.best_position !== head_row.pos) begin
						mismatch_count++;
						$display("%0t: best_position expected %0d got %0d", $time,
							head_row.pos, result_ch.best_position);
					end
					if (result_ch.row_too_long !== head_row.too_long) begin
						mismatch_count++;
						$display("%0t: row_too_long expected %0b got %0b", $time,
							head_row.too_long, result_ch.row_too_long);
					end
				end
			end
			if (elem_ch.valid && elem_ch.ready)
				accumulate_element(elem_ch.element_value, elem_ch.row_last);
		end
	end

	// Result side: stall at random in the current phase
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= result_stall_pct);
	end

	// Present one item, possibly after some idle cycles, and hold it until
	// the unit takes it.
	task automatic send_elem(input logic signed [ELEM_W-1:0] v, input logic last);
		while ($urandom_range(99) < elem_gap_pct) begin
			@(negedge clk);
			elem_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		elem_ch.valid         <= 1'b1;
		elem_ch.element_value <= v;
		elem_ch.row_last      <= last;
		do @(posedge clk); while (elem_ch.ready !== 1'b1);
	endtask

	task automatic send_buf;
		foreach (row_buf[i])
			send_elem(row_buf[i], i == row_buf.size() - 1);
	endtask

	// Drop valid and hold off until every queued result has come back
	task automatic drain_results;
		@(negedge clk);
		elem_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
	endtask

	// Drained, and the unit has finished any element still in flight
	task automatic wait_idle;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		// only the mode word is decoded, and only its low two bits
		if (addr[PADDR_W-1:2] == REG_MODE)
			mode_shadow = mode_t'(data[1:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read_check;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= MODE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[1:0] !== mode_shadow) begin
			mismatch_count++;
			$display("%0t: reduce_mode read expected %0d got %0d", $time,
				mode_shadow, prdata[1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_mode(input mode_t m);
		wait_idle();
		apb_write(MODE_ADDR, PDATA_W'(m));
	endtask

	// Mix of full-range values, small values, extremes and repeats of the
	// previous element so that ties come up often.
	function automatic logic signed [ELEM_W-1:0] rand_element(input logic signed [ELEM_W-1:0] prev);
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4: return $urandom >> $urandom_range(31);
			5, 6: return ELEM_W'(int'($urandom_range(64)) - 32);
			7: return prev;
			8: return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
			default: return ELEM_W'(int'($urandom_range(8)) - 4) <<< 16;
		endcase
	endfunction

	// Single-element extremes, ties, all-negative rows, mean truncation
	task automatic test_extreme_rows;
		set_mode(MODE_SUM);
		row_buf = '{ELEM_MAX};
		send_buf();
		row_buf = '{ELEM_MIN};
		send_buf();
		set_mode(MODE_MAX);
		row_buf = '{-5, -9, -5};
		send_buf();
		row_buf = '{3, 8, 8, 1};
		send_buf();
		set_mode(MODE_ARGMAX);
		row_buf = '{ELEM_MIN, ELEM_MIN};
		send_buf();
		row_buf = '{0, ELEM_MAX};
		send_buf();
		set_mode(MODE_MEAN);
		row_buf = '{-3, 0};
		send_buf();
		row_buf = '{-1};
		send_buf();
		row_buf = '{ELEM_MAX, ELEM_MAX, ELEM_MAX - 1};
		send_buf();
	endtask

	// Mode is read at the row end, so a switch partway through a row counts
	task automatic test_mode_switch_mid_row;
		set_mode(MODE_MEAN);
		send_elem(32'sd10 <<< 16, 1'b0);
		send_elem(32'sd20 <<< 16, 1'b0);
		set_mode(MODE_SUM);
		send_elem(32'sd30 <<< 16, 1'b1);
	endtask

	// Readback, a write to an undecoded word, and a value with high bits set
	task automatic test_register_access;
		wait_idle();
		apb_read_check();
		apb_write(SPARE_ADDR, PDATA_W'(MODE_ARGMAX));
		apb_read_check();
		apb_write(MODE_ADDR, 32'hFFFF_FFFE);
		apb_read_check();
		row_buf = '{1, 7, -2};
		send_buf();
	endtask

	// Long rows sent without gaps; the sums run well past the element width
	task automatic test_long_rows;
		elem_gap_pct     = 0;
		result_stall_pct = 0;
		// increasing values: the argmax lands on the last position
		set_mode(MODE_ARGMAX);
		for (int i = 0; i < LONG_ROW_LEN; i++)
			send_elem(ELEM_W'(i - LONG_ROW_LEN / 2), i == LONG_ROW_LEN - 1);
		// large positive sum
		set_mode(MODE_SUM);
		for (int i = 0; i < LONG_ROW_LEN; i++)
			send_elem(ELEM_MAX, i == LONG_ROW_LEN - 1);
		// large negative mean; the one positive element keeps it from dividing evenly
		set_mode(MODE_MEAN);
		for (int i = 0; i < LONG_ROW_LEN; i++)
			send_elem((i == 0) ? ELEM_MAX : ELEM_MIN, i == LONG_ROW_LEN - 1);
	endtask

	// Random rows, mostly short, through every mode in each idle and stall setting
	task automatic test_random_rows;
		int                       sent;
		int                       len;
		logic signed [ELEM_W-1:0] v;
		for (int seg = 0; seg < 16; seg++) begin
			case (seg / 4)
				0: begin
					elem_gap_pct     = 0;
					result_stall_pct = 0;
				end
				1: begin
					elem_gap_pct     = 53;
					result_stall_pct = 0;
				end
				2: begin
					elem_gap_pct     = 0;
					result_stall_pct = 53;
				end
				default: begin
					elem_gap_pct     = 30;
					result_stall_pct = 30;
				end
			endcase
			set_mode(mode_t'(seg % 4));
			sent = 0;
			v    = '0;
			while (sent < SEGMENT_ITEMS) begin
				len = ($urandom_range(99) < 90) ? $urandom_range(8, 1) : $urandom_range(40, 9);
				for (int i = 0; i < len; i++) begin
					v = rand_element(v);
					send_elem(v, i == len - 1);
					sent++;
				end
				// now and then let everything drain before the next row
				if ($urandom_range(39) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		elem_ch.valid         = 1'b0;
		elem_ch.element_value = '0;
		elem_ch.row_last      = 1'b0;
		result_ch.ready       = 1'b0;
		elem_gap_pct          = 0;
		result_stall_pct      = 0;
		mismatch_count        = 0;
		row_sum               = 0;
		row_best              = '0;
		row_best_pos          = 0;
		row_count             = 0;
		row_open              = 1'b0;
		row_clipped           = 1'b0;
		mode_shadow           = MODE_SUM;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_rows();
		test_mode_switch_mid_row();
		test_register_access();
		test_long_rows();
		test_random_rows();

		wait_idle();
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Hang guard
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== row_reduce_sum_mean_max_argmax_unit.f =====
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_if.sv
hw/rtl/rrs_alu.sv
hw/rtl/rrs_cfg.sv
hw/rtl/row_reduce_sum_mean_max_argmax_unit.sv
hw/rtl/rrs_chk.sv
tb/sv/tb_top.sv
